/* hw/rtl/srr_pkg.sv */
// Shared constants and codes for the selective-repeat receiver.
package srr_pkg;

   localparam int WINDOW_MAX    = 16;
   localparam int PAYLOAD_WIDTH = 32;
   localparam int SEQ_W         = 32;
   localparam int WIN_W         = 5;
   localparam int WIN_RESET     = 16;

   localparam int SLOT_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
   localparam int CNT_W  = $clog2(WINDOW_MAX + 1);

   localparam logic [SEQ_W-1:0] SEQ_ALL_ONES = {SEQ_W{1'b1}};

   localparam logic KIND_ACK     = 1'b0;
   localparam logic KIND_DELIVER = 1'b1;

endpackage

/* hw/rtl/srr_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
module srr_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                                  clock,
   input  logic                                  wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                      wr_data,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                      rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* hw/rtl/selective_repeat_receiver.sv */
// Selective-repeat receiver: one packet in, its acknowledgement and in-order deliveries out.
// Each good packet in the current or previous window gets an acknowledgement beat; data then
// releases its in-order words (one slot checked a cycle), each delivery read from its slot first.
// One packet at a time: a new packet is taken only once the last one is through, and each beat
// waits while rsp_stall holds the one before it.
// Reset (synchronous, active high): base 0, no end seen, all slots empty, window 16.
module selective_repeat_receiver
   import srr_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   // configuration
   input  logic                     csr_write_en,
   input  logic [WIN_W-1:0]         csr_window_size,
   // received packets
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic                     req_checksum_ok,
   input  logic [SEQ_W-1:0]         req_seq_no,
   input  logic                     req_is_end,
   input  logic [PAYLOAD_WIDTH-1:0] req_payload,
   // results
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic                     rsp_result_kind,
   output logic [SEQ_W-1:0]         rsp_out_seq,
   output logic [PAYLOAD_WIDTH-1:0] rsp_out_payload,
   output logic                     rsp_last,
   output logic                     rsp_finished
);

   // Sequencer codes
   localparam logic [3:0] ST_IDLE  = 4'd0;  // take a packet
   localparam logic [3:0] ST_LIMIT = 4'd1;  // form window bounds
   localparam logic [3:0] ST_CLASS = 4'd2;  // classify against both windows
   localparam logic [3:0] ST_STORE = 4'd3;  // park a data word in its slot
   localparam logic [3:0] ST_SCAN  = 4'd4;  // count the in-order run from the base
   localparam logic [3:0] ST_FIN   = 4'd5;  // work out the finished flag
   localparam logic [3:0] ST_ACK   = 4'd6;  // send the acknowledgement beat
   localparam logic [3:0] ST_DRD   = 4'd7;  // wait for slot read data
   localparam logic [3:0] ST_DOUT  = 4'd8;  // send one delivery beat, advance the base

   localparam int SUM_W = CNT_W + 1;

   // Add an offset to a slot index and wrap it round the ring (offset below WINDOW_MAX+1).
   function automatic logic [SLOT_W-1:0] slot_add(input logic [SLOT_W-1:0] idx,
                                                  input logic [CNT_W-1:0]  off);
      logic [SUM_W-1:0] sum;
      sum = SUM_W'(idx) + SUM_W'(off);
      if (sum >= SUM_W'(WINDOW_MAX)) begin
         sum = sum - SUM_W'(WINDOW_MAX);
      end
      return sum[SLOT_W-1:0];
   endfunction

   logic [3:0]               state_ff, state_in;
   logic [WIN_W-1:0]         win_ff, win_in;

   // Receiver state
   logic [SEQ_W-1:0]         base_ff, base_in;
   logic [SLOT_W-1:0]        base_idx_ff, base_idx_in;   // base mod WINDOW_MAX
   logic                     end_seen_ff, end_seen_in;
   logic [SEQ_W-1:0]         end_seq_ff, end_seq_in;
   logic [WINDOW_MAX-1:0]    valid_ff, valid_in;
   logic                     done_ff, done_in;

   // Packet held while it is worked on
   logic [SEQ_W-1:0]         seq_ff, seq_in;
   logic                     is_end_ff, is_end_in;
   logic [PAYLOAD_WIDTH-1:0] data_ff, data_in;
   logic [SEQ_W-1:0]         lower_ff, lower_in;
   logic [SEQ_W:0]           limit_ff, limit_in;
   logic [CNT_W-1:0]         diff_ff, diff_in;
   logic [CNT_W-1:0]         count_ff, count_in;
   logic                     fin_ff, fin_in;

   // Output register
   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     rsp_kind_ff, rsp_kind_in;
   logic [SEQ_W-1:0]         rsp_seq_ff, rsp_seq_in;
   logic [PAYLOAD_WIDTH-1:0] rsp_payload_ff, rsp_payload_in;
   logic                     rsp_last_ff, rsp_last_in;
   logic                     rsp_fin_ff, rsp_fin_in;

   // Slot store
   logic                     ram_wr_en;
   logic [SLOT_W-1:0]        ram_wr_addr;
   logic [PAYLOAD_WIDTH-1:0] ram_rd_data;

   logic [CNT_W-1:0]         win_eff;
   logic [SLOT_W-1:0]        store_idx;
   logic [SLOT_W-1:0]        scan_idx;
   logic [SEQ_W-1:0]         base_end;
   logic                     in_prev;
   logic                     in_win;
   logic                     out_free;
   logic                     req_take;

   srr_ram #(
      .WIDTH (PAYLOAD_WIDTH),
      .DEPTH (WINDOW_MAX)
   ) u_slots (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (data_ff),
      .rd_addr (base_idx_ff),
      .rd_data (ram_rd_data)
   );

   // Clamp the window to the ring depth
   assign win_eff = (32'(win_ff) > WINDOW_MAX) ? CNT_W'(WINDOW_MAX) : CNT_W'(win_ff);

   assign store_idx = slot_add(base_idx_ff, diff_ff);
   assign scan_idx  = slot_add(base_idx_ff, count_ff);
   assign base_end  = base_ff + SEQ_W'(count_ff);

   assign in_prev = (seq_ff < base_ff) && (seq_ff >= lower_ff);
   assign in_win  = (seq_ff >= base_ff) && ({1'b0, seq_ff} < limit_ff);

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && (state_ff == ST_IDLE);

   assign ram_wr_en   = (state_ff == ST_STORE) && !valid_ff[store_idx];
   assign ram_wr_addr = store_idx;

   always_comb begin
      state_in       = state_ff;
      win_in         = csr_write_en ? csr_window_size : win_ff;
      base_in        = base_ff;
      base_idx_in    = base_idx_ff;
      end_seen_in    = end_seen_ff;
      end_seq_in     = end_seq_ff;
      valid_in       = valid_ff;
      done_in        = done_ff;
      seq_in         = seq_ff;
      is_end_in      = is_end_ff;
      data_in        = data_ff;
      lower_in       = lower_ff;
      limit_in       = limit_ff;
      diff_in        = diff_ff;
      count_in       = count_ff;
      fin_in         = fin_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_kind_in    = rsp_kind_ff;
      rsp_seq_in     = rsp_seq_ff;
      rsp_payload_in = rsp_payload_ff;
      rsp_last_in    = rsp_last_ff;
      rsp_fin_in     = rsp_fin_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               seq_in    = req_seq_no;
               is_end_in = req_is_end;
               data_in   = req_payload;
               // Drop bad beats, and everything once the transfer is done
               if (req_checksum_ok && !done_ff) begin
                  state_in = ST_LIMIT;
               end
            end
         end
         ST_LIMIT: begin
            // Lower bound clamps at zero; upper bound is kept one bit wider so it cannot wrap
            lower_in = (base_ff >= SEQ_W'(win_eff)) ? base_ff - SEQ_W'(win_eff) : '0;
            limit_in = {1'b0, base_ff} + (SEQ_W + 1)'(win_eff);
            state_in = ST_CLASS;
         end
         ST_CLASS: begin
            diff_in  = CNT_W'(seq_ff - base_ff);
            count_in = '0;
            priority if (in_prev) begin
               state_in = ST_FIN;
            end else if (in_win && is_end_ff) begin
               end_seen_in = 1'b1;
               end_seq_in  = seq_ff;
               state_in    = ST_FIN;
            end else if (in_win) begin
               state_in = ST_STORE;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_STORE: begin
            // A duplicate keeps the word already held
            valid_in[store_idx] = 1'b1;
            state_in            = ST_SCAN;
         end
         ST_SCAN: begin
            if ((count_ff == CNT_W'(WINDOW_MAX)) || !valid_ff[scan_idx]) begin
               state_in = ST_FIN;
            end else begin
               count_in = count_ff + CNT_W'(1);
            end
         end
         ST_FIN: begin
            fin_in   = end_seen_ff && (base_end == end_seq_ff);
            done_in  = end_seen_ff && (base_end == end_seq_ff);
            state_in = ST_ACK;
         end
         ST_ACK: begin
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_kind_in    = KIND_ACK;
               rsp_seq_in     = seq_ff;
               rsp_payload_in = '0;
               rsp_last_in    = (count_ff == '0);
               rsp_fin_in     = fin_ff;
               state_in       = (count_ff == '0) ? ST_IDLE : ST_DRD;
            end
         end
         ST_DRD: begin
            state_in = ST_DOUT;
         end
         ST_DOUT: begin
            if (out_free) begin
               rsp_valid_in          = 1'b1;
               rsp_kind_in           = KIND_DELIVER;
               rsp_seq_in            = base_ff;
               rsp_payload_in        = ram_rd_data;
               rsp_last_in           = (count_ff == CNT_W'(1));
               rsp_fin_in            = fin_ff;
               // Free the slot and advance the base, wrapping the ring index with it
               valid_in[base_idx_ff] = 1'b0;
               base_in               = base_ff + SEQ_W'(1);
               if ((base_ff == SEQ_ALL_ONES) || (base_idx_ff == SLOT_W'(WINDOW_MAX - 1))) begin
                  base_idx_in = '0;
               end else begin
                  base_idx_in = base_idx_ff + SLOT_W'(1);
               end
               count_in = count_ff - CNT_W'(1);
               state_in = (count_ff == CNT_W'(1)) ? ST_IDLE : ST_DRD;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         win_ff       <= WIN_W'(WIN_RESET);
         base_ff      <= '0;
         base_idx_ff  <= '0;
         end_seen_ff  <= 1'b0;
         end_seq_ff   <= SEQ_ALL_ONES;
         valid_ff     <= '0;
         done_ff      <= 1'b0;
         count_ff     <= '0;
         fin_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         win_ff       <= win_in;
         base_ff      <= base_in;
         base_idx_ff  <= base_idx_in;
         end_seen_ff  <= end_seen_in;
         end_seq_ff   <= end_seq_in;
         valid_ff     <= valid_in;
         done_ff      <= done_in;
         count_ff     <= count_in;
         fin_ff       <= fin_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers: no reset
   always_ff @(posedge clock) begin
      seq_ff         <= seq_in;
      is_end_ff      <= is_end_in;
      data_ff        <= data_in;
      lower_ff       <= lower_in;
      limit_ff       <= limit_in;
      diff_ff        <= diff_in;
      rsp_kind_ff    <= rsp_kind_in;
      rsp_seq_ff     <= rsp_seq_in;
      rsp_payload_ff <= rsp_payload_in;
      rsp_last_ff    <= rsp_last_in;
      rsp_fin_ff     <= rsp_fin_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_result_kind = rsp_kind_ff;
   assign rsp_out_seq     = rsp_seq_ff;
   assign rsp_out_payload = rsp_payload_ff;
   assign rsp_last        = rsp_last_ff;
   assign rsp_finished    = rsp_fin_ff;

endmodule

/* tb/selective_repeat_receiver_tb.sv */
`timescale 1ns / 100ps
// Testbench for the selective-repeat receiver: directed and random packets checked against a predictor.
module selective_repeat_receiver_tb;
   import srr_pkg::*;

   // One received packet as the sender presents it.
   typedef struct packed {
      logic                     checksum_ok;
      logic [SEQ_W-1:0]         seq;
      logic                     is_end;
      logic [PAYLOAD_WIDTH-1:0] payload;
   } packet_type;

   // One result beat: an acknowledgement or an in-order delivery.
   typedef struct packed {
      logic                     kind;
      logic [SEQ_W-1:0]         seq;
      logic [PAYLOAD_WIDTH-1:0] word;
      logic                     last;
      logic                     finished;
   } beat_type;

   // Receiver state as the predictor keeps it.
   typedef struct packed {
      logic [WIN_W-1:0]                           window;
      logic [SEQ_W-1:0]                           base;
      logic                                       end_seen;
      logic [SEQ_W-1:0]                           end_seq;
      logic [WINDOW_MAX-1:0]                      held;
      logic [WINDOW_MAX-1:0][PAYLOAD_WIDTH-1:0]   held_word;
   } rx_state_type;

   localparam int SETTLE_CYCLES = 40;

   logic                     clock;
   logic                     reset;
   logic                     csr_write_en;
   logic [WIN_W-1:0]         csr_window_size;
   logic                     req_valid;
   logic                     req_stall;
   logic                     req_checksum_ok;
   logic [SEQ_W-1:0]         req_seq_no;
   logic                     req_is_end;
   logic [PAYLOAD_WIDTH-1:0] req_payload;
   logic                     rsp_valid;
   logic                     rsp_stall;
   logic                     rsp_result_kind;
   logic [SEQ_W-1:0]         rsp_out_seq;
   logic [PAYLOAD_WIDTH-1:0] rsp_out_payload;
   logic                     rsp_last;
   logic                     rsp_finished;

   rx_state_type rx;
   beat_type     pending_beats[$];
   beat_type     step_beats[0:WINDOW_MAX];
   int           step_count;
   beat_type     beat_due;
   int           error_count;
   int           burst_left;
   int           stall_left;
   int           stall_mode;

   selective_repeat_receiver u_dut (
      .clock           (clock),
      .reset           (reset),
      .csr_write_en    (csr_write_en),
      .csr_window_size (csr_window_size),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_checksum_ok (req_checksum_ok),
      .req_seq_no      (req_seq_no),
      .req_is_end      (req_is_end),
      .req_payload     (req_payload),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_result_kind (rsp_result_kind),
      .rsp_out_seq     (rsp_out_seq),
      .rsp_out_payload (rsp_out_payload),
      .rsp_last        (rsp_last),
      .rsp_finished    (rsp_finished)
   );

   always #5 clock = ~clock;

   // ---------------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------------

   function automatic logic rx_finished();
      return rx.end_seen && (rx.base == rx.end_seq);
   endfunction

   task automatic add_beat(input logic kind, input logic [SEQ_W-1:0] seq,
                           input logic [PAYLOAD_WIDTH-1:0] word);
      step_beats[step_count] = '{kind: kind, seq: seq, word: word, last: 1'b0,
                                 finished: 1'b0};
      step_count++;
   endtask

   // Advance the receiver state by one packet; leave its beats in step_beats.
   task automatic advance_receiver(input packet_type p);
      int unsigned      w;
      int unsigned      slot;
      logic [SEQ_W-1:0] lower;
      logic [SEQ_W:0]   upper;
      logic             fin;
      step_count = 0;
      // once finished, everything is ignored until reset; bad checksums are dropped
      if (!rx_finished() && p.checksum_ok) begin
         // clamp an over-wide window to the ring depth
         w = (rx.window > WINDOW_MAX) ? WINDOW_MAX : rx.window;
         // the previous window stops at zero rather than wrapping
         lower = (rx.base >= w) ? rx.base - w : '0;
         // the upper limit is taken without wrap, so the window shortens near the top
         upper = {1'b0, rx.base} + w;
         if (p.seq < rx.base && p.seq >= lower) begin
            add_beat(KIND_ACK, p.seq, '0);
         end else if (p.seq >= rx.base && {1'b0, p.seq} < upper) begin
            add_beat(KIND_ACK, p.seq, '0);
            if (p.is_end) begin
               // a later end replaces the recorded one
               rx.end_seen = 1'b1;
               rx.end_seq  = p.seq;
            end else begin
               slot = p.seq % WINDOW_MAX;
               // keep the first copy of a duplicate
               if (!rx.held[slot]) begin
                  rx.held[slot]      = 1'b1;
                  rx.held_word[slot] = p.payload;
               end
               slot = rx.base % WINDOW_MAX;
               while (rx.held[slot]) begin
                  add_beat(KIND_DELIVER, rx.base, rx.held_word[slot]);
                  rx.held[slot] = 1'b0;
                  rx.base       = rx.base + 1'b1;
                  slot          = rx.base % WINDOW_MAX;
               end
            end
         end
      end
      fin = rx_finished();
      for (int k = 0; k < step_count; k++) begin
         step_beats[k].last     = (k == step_count - 1);
         step_beats[k].finished = fin;
      end
   endtask

   // ---------------------------------------------------------------------
   // Sender, result check and receiver stalls
   // ---------------------------------------------------------------------

   // Present one packet, hold it until accepted, then record its beats.
   task automatic send_packet(input packet_type p);
      int gap;
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         gap = ($urandom_range(0, 3) == 0) ? $urandom_range(8, 20) : $urandom_range(1, 4);
         repeat (gap) @(posedge clock);
         // now and then a long burst with no gaps at all
         burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 60)
                                                  : $urandom_range(1, 8);
      end
      req_valid       <= 1'b1;
      req_checksum_ok <= p.checksum_ok;
      req_seq_no      <= p.seq;
      req_is_end      <= p.is_end;
      req_payload     <= p.payload;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      burst_left--;
      advance_receiver(p);
      for (int k = 0; k < step_count; k++) pending_beats.push_back(step_beats[k]);
   endtask

   // Stop sending, wait for every expected beat, then let the block settle.
   task automatic drain();
      req_valid  <= 1'b0;
      burst_left = 0;
      while (pending_beats.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write the window register; call only while the block is idle.
   task automatic write_window(input logic [WIN_W-1:0] value);
      csr_write_en    <= 1'b1;
      csr_window_size <= value;
      @(posedge clock);
      csr_write_en <= 1'b0;
      rx.window = value;
   endtask

   task automatic send_data(input logic [SEQ_W-1:0] seq, input logic [PAYLOAD_WIDTH-1:0] word);
      send_packet('{checksum_ok: 1'b1, seq: seq, is_end: 1'b0, payload: word});
   endtask

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
         error_count++;
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_beats.size() == 0) begin
            $display("%0t: unexpected result beat, expected none actual kind %0d seq %h payload %h",
                     $time, rsp_result_kind, rsp_out_seq, rsp_out_payload);
            error_count++;
         end else begin
            beat_due = pending_beats.pop_front();
            check_field("result_kind", 32'(beat_due.kind), 32'(rsp_result_kind));
            check_field("out_seq", beat_due.seq, rsp_out_seq);
            check_field("out_payload", beat_due.word, rsp_out_payload);
            check_field("last", 32'(beat_due.last), 32'(rsp_last));
            check_field("finished", 32'(beat_due.finished), 32'(rsp_finished));
         end
      end
   end

   // Receiver back-pressure: switch between free flow, light and heavy stalling.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall  <= 1'b0;
         stall_left <= 0;
         stall_mode <= 0;
      end else begin
         if (stall_left == 0) begin
            stall_mode <= $urandom_range(0, 2);
            stall_left <= $urandom_range(20, 150);
         end else begin
            stall_left <= stall_left - 1;
         end
         case (stall_mode)
            0: begin
               rsp_stall <= 1'b0;
            end
            1: begin
               rsp_stall <= ($urandom_range(0, 3) == 0);
            end
            default: begin
               rsp_stall <= ($urandom_range(0, 9) < 7);
            end
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // Out-of-order arrival, duplicates, re-acks and window edges from a fresh reset.
   task automatic test_in_order_and_duplicates();
      send_packet('{checksum_ok: 1'b0, seq: '0, is_end: 1'b0, payload: '1});
      send_data(0, '1);
      send_data(3, '0);
      send_data(2, 32'hA5A5_5A5A);
      send_data(3, 32'h1234_5678);          // duplicate: keep the first word
      send_data(1, 32'h0F0F_F0F0);          // releases 1, 2 and 3
      send_data(0, 32'hDEAD_BEEF);          // previous window, lower bound clamped at zero
      send_data(SEQ_ALL_ONES, 32'h5555_AAAA); // below the clamp, no wrap: drop
      send_data(20, 32'h0000_0001);         // one past the window: drop
      send_data(19, 32'h8000_0000);         // last slot of the window
   endtask

   // Fill the whole window behind a gap, then close it for the longest burst of deliveries.
   task automatic test_full_window();
      for (int s = 18; s >= 5; s--) send_data(s, $urandom);
      send_data(4, $urandom);
   endtask

   // Window of zero, an over-wide window and a window of one.
   task automatic test_window_settings();
      logic [SEQ_W-1:0] b;
      drain();
      write_window(0);
      b = rx.base;
      send_data(b, $urandom);
      send_data(b + 1, $urandom);
      send_data(b - 1, $urandom);
      drain();
      write_window(31);
      b = rx.base;
      send_data(b + 15, $urandom);
      send_data(b + 16, $urandom);
      send_data(b - 16, $urandom);
      send_data(b - 17, $urandom);
      drain();
      write_window(1);
      b = rx.base;
      send_data(b + 1, $urandom);
      send_data(b - 1, $urandom);
      send_data(b - 2, $urandom);
      send_data(b, $urandom);
      drain();
   endtask

   // Draw a packet around the current window, mostly well formed.
   task automatic draw_packet(output packet_type p);
      int unsigned w;
      int unsigned span;
      int unsigned pick;
      w = (rx.window == 0 || rx.window > WINDOW_MAX) ? WINDOW_MAX : rx.window;
      pick = $urandom_range(0, 99);
      p.is_end = 1'b0;
      if (pick < 68) begin
         p.seq    = rx.base + $urandom_range(0, w - 1);
         p.is_end = ($urandom_range(0, 99) < 4);
      end else if (pick < 80 && rx.base != 0) begin
         span  = (rx.base < w) ? rx.base : w;
         p.seq = rx.base - $urandom_range(1, span);
      end else if (pick < 88) begin
         p.seq = ($urandom_range(0, 1) == 0) ? rx.base + w + $urandom_range(0, 3)
                                             : rx.base - w - 1;
      end else begin
         p.seq    = $urandom;
         p.is_end = 1'($urandom_range(0, 1));
      end
      p.checksum_ok = ($urandom_range(0, 99) >= 7);
      pick = $urandom_range(0, 9);
      p.payload = (pick == 0) ? '0 : (pick == 1) ? '1 : $urandom;
   endtask

   // Random traffic over several window settings; hold back anything that would finish.
   task automatic test_random_traffic();
      int           windows[7];
      int           count;
      packet_type   p;
      rx_state_type saved;
      logic         would_finish;
      windows = '{16, 1, 31, 0, 5, 2, 16};
      windows[5] = $urandom_range(2, 30);
      foreach (windows[i]) begin
         drain();
         write_window(WIN_W'(windows[i]));
         count = (windows[i] == 0) ? 10 : 32;
         for (int n = 0; n < count; n++) begin
            draw_packet(p);
            saved = rx;
            advance_receiver(p);
            would_finish = rx_finished();
            rx = saved;
            // drop the checksum rather than end the transfer early
            if (would_finish) p.checksum_ok = 1'b0;
            send_packet(p);
            // pause until the results have caught up
            if (n == count / 2) drain();
         end
      end
   endtask

   // Repeated end packet, completion of the transfer and packets after finish.
   task automatic test_end_of_transfer();
      logic [SEQ_W-1:0] b;
      int               k;
      drain();
      write_window(16);
      b = rx.base;
      // pick the first empty slot above the base as the end
      for (k = 1; k < WINDOW_MAX; k++) begin
         if (!rx.held[(b + k) % WINDOW_MAX]) break;
      end
      if (k == WINDOW_MAX) k = 0;
      send_packet('{checksum_ok: 1'b1, seq: b + 15, is_end: 1'b1, payload: '1});
      send_packet('{checksum_ok: 1'b1, seq: b + k, is_end: 1'b1, payload: $urandom});
      for (int j = k - 1; j >= 0; j--) begin
         if (!rx.held[(b + j) % WINDOW_MAX]) send_data(b + j, $urandom);
      end
      // finished: these are ignored
      send_data(rx.base, $urandom);
      send_packet('{checksum_ok: 1'b1, seq: rx.base, is_end: 1'b1, payload: '0});
      send_data(rx.base - 1, $urandom);
   endtask

   initial begin
      clock           = 1'b0;
      reset           = 1'b1;
      csr_write_en    = 1'b0;
      csr_window_size = '0;
      req_valid       = 1'b0;
      req_checksum_ok = 1'b0;
      req_seq_no      = '0;
      req_is_end      = 1'b0;
      req_payload     = '0;
      error_count     = 0;
      burst_left      = 0;
      rx              = '0;
      rx.window       = WIN_RESET;
      rx.end_seq      = SEQ_ALL_ONES;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_in_order_and_duplicates();
      test_full_window();
      test_window_settings();
      test_random_traffic();
      test_end_of_transfer();
      drain();
      if (error_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   // Guard against a hung handshake.
   initial begin
      #10_000_000;
      $display("Test completed with failures");
      $finish;
   end

endmodule
